// ===== hw/rtl/srsc_pkg.sv =====
// ----------------------------------------------------------------------------
// srsc_pkg
// Shared types, constants and the CRC32 byte step for the sorted run checker.
// ----------------------------------------------------------------------------
package srsc_pkg;

  localparam int unsigned MaxKeyBytes = 4096;
  localparam int unsigned OutDepth    = 4;

  localparam logic [63:0] RunMagic    = 64'h524F_5254_534B_4445;
  localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes     = 32'hFFFF_FFFF;
  localparam logic [31:0] HdrBytes    = 32'd48;
  localparam logic [31:0] HdrCrcAt    = 32'd36;
  localparam logic [31:0] FixedBytes  = 32'd12;
  localparam logic [31:0] RunFormat   = 32'd1;
  localparam logic [12:0] LimitReset  = 13'd4108;

  typedef enum logic [2:0] {
    PH_HDR, PH_HDR_BAD, PH_FIXED, PH_KEY, PH_END, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    ORD_EQ, ORD_LESS, ORD_GREATER
  } order_e;

  typedef enum logic [1:0] {
    EV_HEADER, EV_RECORD, EV_VERIFIED, EV_ERROR
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_HDR_ID, ERR_HDR_CHECK, ERR_REC_LEN,
    ERR_UNSORTED, ERR_PAYLOAD, ERR_TRAILING, ERR_TRUNCATED
  } err_e;

  typedef struct packed {
    event_e      kind;
    err_e        err;
    logic [63:0] value;
    logic [12:0] klen;
    logic [63:0] recnum;
    logic        last;
  } result_t;

  // results produced by one item, at most two
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic result_t make_res(event_e kind, err_e err, logic [63:0] value,
                                       logic [12:0] klen, logic [63:0] recnum,
                                       logic last);
    result_t r;
    r.kind   = kind;
    r.err    = err;
    r.value  = value;
    r.klen   = klen;
    r.recnum = recnum;
    r.last   = last;
    return r;
  endfunction

endpackage

// ===== hw/rtl/sorted_run_stream_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_run_stream_checker
// Byte-serial checker for a sorted run file: header, records, order, CRCs.
// ----------------------------------------------------------------------------
// One file byte is taken per clock cycle. Header and record bytes each pass
// through one CRC32 byte step; key bytes are also compared with the previous
// key byte, registered out of an on-chip key memory ahead of use. Results go
// into a four-entry queue; the input side stalls only while that queue holds
// more than two results. After a run verified or error result the block keeps
// taking bytes and drops them until reset. The user must write the record size
// limit register through the cfg channel while the block is idle (not enforced).
module sorted_run_stream_checker #(
  parameter int unsigned MAX_KEY_BYTES = srsc_pkg::MaxKeyBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [12:0]   cfg_data_i,     // record_size_limit
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // stream_byte
  input  logic          s_axis_tlast,   // final_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // error_code, record_value, key_length, record_number
  output logic [1:0]    m_axis_tuser,   // event_kind
  output logic          m_axis_tlast    // last_of_run
);
  import srsc_pkg::*;

  localparam int unsigned KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned PW  = (KLW > 6) ? KLW : 6;
  localparam int unsigned AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  phase_e          phase_q, phase_d;
  logic [PW-1:0]   pos_q, pos_d, pos_n;
  logic [63:0]     shift_q, shift_d, sh;
  logic [63:0]     exp_rec_q, exp_rec_d;
  logic [63:0]     rem_q, rem_d;
  logic [31:0]     exp_crc_q, exp_crc_d;
  logic [31:0]     hdr_crc_q, hdr_crc_d;
  logic [31:0]     hcrc_q, hcrc_d;
  logic [31:0]     pcrc_q, pcrc_d;
  logic [63:0]     rec_q, rec_d;
  logic [31:0]     klen_q, klen_d;
  logic [63:0]     value_q, value_d;
  logic [KLW-1:0]  prev_klen_q, prev_klen_d;
  logic [63:0]     prev_value_q, prev_value_d;
  logic            has_prev_q, has_prev_d;
  order_e          order_q, order_d;
  logic [12:0]     limit_q;

  logic [7:0]      key_mem [MAX_KEY_BYTES];
  logic [7:0]      rdata_q;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;

  logic            s_acc, fin, bad, do_complete, do_after, unsorted;
  logic [7:0]      b;
  logic [31:0]     hi, lim_key;
  logic [63:0]     cval;
  order_e          cord;
  push_t           push;
  logic            space;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = space;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign b             = s_axis_tdata;
  assign fin           = s_axis_tlast;
  assign sh            = {b, shift_q[63:8]};
  assign hi            = sh[63:32];

  always_comb begin
    lim_key = (limit_q < 13'd12) ? 32'd0 : (32'(limit_q) - FixedBytes);
    if (lim_key > 32'(MAX_KEY_BYTES)) begin
      lim_key = 32'(MAX_KEY_BYTES);
    end
  end

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    pos_n        = pos_q + PW'(1);
    shift_d      = shift_q;
    exp_rec_d    = exp_rec_q;
    rem_d        = rem_q;
    exp_crc_d    = exp_crc_q;
    hdr_crc_d    = hdr_crc_q;
    hcrc_d       = hcrc_q;
    pcrc_d       = pcrc_q;
    rec_d        = rec_q;
    klen_d       = klen_q;
    value_d      = value_q;
    prev_klen_d  = prev_klen_q;
    prev_value_d = prev_value_q;
    has_prev_d   = has_prev_q;
    order_d      = order_q;
    mem_we       = 1'b0;
    bad          = 1'b0;
    do_complete  = 1'b0;
    do_after     = 1'b0;
    unsorted     = 1'b0;
    cval         = value_q;
    cord         = order_q;
    push         = '0;

    if (s_acc) begin
      unique case (phase_q)
        PH_HDR, PH_HDR_BAD: begin
          hcrc_d  = crc_byte(hcrc_q, (32'(pos_q) >= HdrCrcAt &&
                                      32'(pos_q) < HdrCrcAt + 32'd4) ? 8'd0 : b);
          shift_d = sh;
          bad     = (phase_q == PH_HDR_BAD);
          if (pos_q == PW'(7) && sh != RunMagic) bad = 1'b1;
          if (pos_q == PW'(11) && hi != RunFormat) bad = 1'b1;
          if (pos_q == PW'(15) && hi != HdrBytes) bad = 1'b1;
          if (pos_q == PW'(23)) exp_rec_d = sh;
          if (pos_q == PW'(31)) rem_d = sh;
          if (pos_q == PW'(35)) exp_crc_d = hi;
          if (pos_q == PW'(39)) hdr_crc_d = hi;
          phase_d = bad ? PH_HDR_BAD : PH_HDR;
          if (32'(pos_q) < HdrBytes - 32'd1) begin
            pos_d = pos_n;
            if (fin) begin
              phase_d = PH_HALT;
              push.r0 = make_res(EV_ERROR, ERR_TRUNCATED, '0, '0, rec_q, 1'b1);
              push.n  = 2'd1;
            end
          end else if (bad) begin
            phase_d = PH_HALT;
            push.r0 = make_res(EV_ERROR, ERR_HDR_ID, '0, '0, rec_q, 1'b1);
            push.n  = 2'd1;
          end else if (!(sh >= 64'(HdrBytes) && (sh - 64'(HdrBytes)) == rem_q) ||
                       ((hcrc_d ^ CrcOnes) != hdr_crc_q)) begin
            phase_d = PH_HALT;
            push.r0 = make_res(EV_ERROR, ERR_HDR_CHECK, '0, '0, rec_q, 1'b1);
            push.n  = 2'd1;
          end else begin
            push.r0  = make_res(EV_HEADER, ERR_NONE, '0, '0, rec_q, 1'b0);
            push.n   = 2'd1;
            phase_d  = PH_FIXED;
            pos_d    = '0;
            do_after = 1'b1;
          end
        end

        PH_FIXED: begin
          pcrc_d  = crc_byte(pcrc_q, b);
          shift_d = sh;
          if (pos_q == PW'(3)) klen_d = hi;
          if (32'(pos_q) < FixedBytes - 32'd1) begin
            pos_d = pos_n;
            if (fin) begin
              phase_d = PH_HALT;
              push.r0 = make_res(EV_ERROR, ERR_TRUNCATED, '0, '0, rec_q, 1'b1);
              push.n  = 2'd1;
            end
          end else begin
            value_d = sh;
            if (rem_q < 64'(FixedBytes) || klen_q > lim_key ||
                64'(klen_q) > rem_q - 64'(FixedBytes)) begin
              phase_d = PH_HALT;
              push.r0 = make_res(EV_ERROR, ERR_REC_LEN, '0, '0, rec_q, 1'b1);
              push.n  = 2'd1;
            end else begin
              order_d = ORD_EQ;
              pos_d   = '0;
              rem_d   = rem_q - 64'(FixedBytes) - 64'(klen_q);
              if (klen_q == 32'd0) begin
                do_complete = 1'b1;
                cval        = sh;
                cord        = ORD_EQ;
              end else begin
                phase_d = PH_KEY;
                if (fin) begin
                  phase_d = PH_HALT;
                  push.r0 = make_res(EV_ERROR, ERR_TRUNCATED, '0, '0, rec_q, 1'b1);
                  push.n  = 2'd1;
                end
              end
            end
          end
        end

        PH_KEY: begin
          pcrc_d = crc_byte(pcrc_q, b);
          cord   = order_q;
          if (order_q == ORD_EQ) begin
            if (32'(pos_q) < 32'(prev_klen_q)) begin
              if (b < rdata_q) cord = ORD_LESS;
              else if (b > rdata_q) cord = ORD_GREATER;
            end else begin
              cord = ORD_GREATER;
            end
          end
          order_d = cord;
          mem_we  = 1'b1;
          pos_d   = pos_n;
          cval    = value_q;
          if (32'(pos_n) >= klen_q) begin
            do_complete = 1'b1;
          end else if (fin) begin
            phase_d = PH_HALT;
            push.r0 = make_res(EV_ERROR, ERR_TRUNCATED, '0, '0, rec_q, 1'b1);
            push.n  = 2'd1;
          end
        end

        PH_END: begin
          phase_d = PH_HALT;
          push.r0 = make_res(EV_ERROR, ERR_TRAILING, '0, '0, rec_q, 1'b1);
          push.n  = 2'd1;
        end

        default: begin
          // halted: drop the item
        end
      endcase

      if (do_complete) begin
        unsorted = has_prev_q &&
                   (cord == ORD_LESS ||
                    (cord == ORD_EQ &&
                     (32'(klen_q) < 32'(prev_klen_q) ||
                      (32'(klen_q) == 32'(prev_klen_q) && cval < prev_value_q))));
        if (unsorted) begin
          phase_d = PH_HALT;
          push.r0 = make_res(EV_ERROR, ERR_UNSORTED, '0, '0, rec_q, 1'b1);
          push.n  = 2'd1;
        end else begin
          rec_d        = rec_q + 64'd1;
          prev_klen_d  = KLW'(klen_q);
          prev_value_d = cval;
          has_prev_d   = 1'b1;
          push.r0      = make_res(EV_RECORD, ERR_NONE, cval, klen_q[12:0], rec_d, 1'b0);
          push.n       = 2'd1;
          phase_d      = PH_FIXED;
          pos_d        = '0;
          do_after     = 1'b1;
        end
      end

      // both callers leave exactly one result in r0, so the follow-up goes to r1
      if (do_after) begin
        if (rec_d == exp_rec_q) begin
          if (rem_d != 64'd0 || (pcrc_d ^ CrcOnes) != exp_crc_q) begin
            phase_d = PH_HALT;
            push.r1 = make_res(EV_ERROR, ERR_PAYLOAD, '0, '0, rec_d, 1'b1);
            push.n  = 2'd2;
          end else if (fin) begin
            phase_d = PH_HALT;
            push.r1 = make_res(EV_VERIFIED, ERR_NONE, '0, '0, rec_d, 1'b1);
            push.n  = 2'd2;
          end else begin
            phase_d = PH_END;
          end
        end else if (fin) begin
          phase_d = PH_HALT;
          push.r1 = make_res(EV_ERROR, ERR_TRUNCATED, '0, '0, rec_d, 1'b1);
          push.n  = 2'd2;
        end
      end
    end
  end

  // fetch the previous key byte for the position the next item will use
  assign rd_addr = (phase_d == PH_KEY) ? pos_d[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[pos_q[AW-1:0]] <= b;
    end
    rdata_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR;
      pos_q        <= '0;
      shift_q      <= '0;
      exp_rec_q    <= '0;
      rem_q        <= '0;
      exp_crc_q    <= '0;
      hdr_crc_q    <= '0;
      hcrc_q       <= CrcOnes;
      pcrc_q       <= CrcOnes;
      rec_q        <= '0;
      klen_q       <= '0;
      value_q      <= '0;
      prev_klen_q  <= '0;
      prev_value_q <= '0;
      has_prev_q   <= 1'b0;
      order_q      <= ORD_EQ;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      shift_q      <= shift_d;
      exp_rec_q    <= exp_rec_d;
      rem_q        <= rem_d;
      exp_crc_q    <= exp_crc_d;
      hdr_crc_q    <= hdr_crc_d;
      hcrc_q       <= hcrc_d;
      pcrc_q       <= pcrc_d;
      rec_q        <= rec_d;
      klen_q       <= klen_d;
      value_q      <= value_d;
      prev_klen_q  <= prev_klen_d;
      prev_value_q <= prev_value_d;
      has_prev_q   <= has_prev_d;
      order_q      <= order_d;
    end
  end

  srsc_out_fifo #(
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .space_o       (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |=> phase_q == PH_HALT)
    else $error("left halt without reset");

  a_key_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY |-> (32'(pos_q) < klen_q && klen_q <= 32'(MAX_KEY_BYTES)))
    else $error("key position out of range");

  a_fixed_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FIXED |-> 32'(pos_q) < FixedBytes)
    else $error("fixed field position out of range");

  a_record_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && phase_q == PH_END) |=> phase_q == PH_HALT)
    else $error("trailing byte not reported");
`endif

endmodule

// ===== hw/rtl/srsc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// srsc_out_fifo
// Small result queue; takes up to two results a cycle, delivers one when the receiver is ready.
// ----------------------------------------------------------------------------
module srsc_out_fifo #(
  parameter int unsigned Depth = srsc_pkg::OutDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srsc_pkg::push_t  push_i,
  output logic             space_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [143:0]     m_axis_tdata,  // error_code, record_value, key_length, record_number
  output logic [1:0]       m_axis_tuser,  // event_kind
  output logic             m_axis_tlast   // last_of_run
);
  import srsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  result_t         slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;
  result_t         head;

  assign head          = slot_q[rd_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {head.recnum, head.klen, head.value, head.err};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign space_o       = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign pop           = m_axis_tvalid & m_axis_tready;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.n);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + (PtrW+1)'(push_i.n) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      slot_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      slot_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== test/sorted_run_scoreboard.sv =====
// ----------------------------------------------------------------------------
// sorted_run_scoreboard
// Watches the checker's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Each accepted file byte runs through a cycle-free model of the header
// parse, record parse, key order and CRC bookkeeping. The model queues the
// results that byte causes. Each result taken from the master side is
// compared field by field with the oldest queued one.
module sorted_run_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [12:0]  cfg_data_i,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [7:0]   s_data_i,
  input  logic         s_last_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [143:0] m_data_i,
  input  logic [1:0]   m_user_i,
  input  logic         m_last_i,
  output int           pending_o,
  output int           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import srsc_pkg::*;

  result_t     due_results[$];

  logic [12:0] size_limit;
  phase_e      ph;
  logic [31:0] pos;
  logic [63:0] shift_reg;
  logic [63:0] want_recs;
  logic [63:0] want_bytes;
  logic [31:0] want_pcrc;
  logic [31:0] hdr_crc_field;
  logic [31:0] hdr_crc;
  logic [31:0] pay_crc;
  logic [63:0] bytes_seen;
  logic [63:0] recs_seen;
  logic [31:0] klen;
  logic [63:0] cur_val;
  logic [7:0]  prev_key[MaxKeyBytes];
  logic [31:0] prev_klen;
  logic [63:0] prev_val;
  bit          has_prev;
  order_e      ord;

  function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

  task automatic post(event_e kind, err_e err, logic [63:0] value, logic [12:0] kl,
                      logic last);
    result_t r;
    r.kind   = kind;
    r.err    = err;
    r.value  = value;
    r.klen   = kl;
    r.recnum = recs_seen;
    r.last   = last;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic halt_with(err_e err);
    ph = PH_HALT;
    post(EV_ERROR, err, '0, '0, 1'b1);
  endtask

  task automatic close_count(bit fin);
    if (recs_seen == want_recs) begin
      if (bytes_seen != want_bytes || (pay_crc ^ CrcOnes) != want_pcrc) begin
        halt_with(ERR_PAYLOAD);
      end else if (fin) begin
        ph = PH_HALT;
        post(EV_VERIFIED, ERR_NONE, '0, '0, 1'b1);
      end else begin
        ph = PH_END;
      end
    end else if (fin) begin
      halt_with(ERR_TRUNCATED);
    end
  endtask

  task automatic close_record(bit fin);
    bit unsorted;
    bytes_seen += 64'(FixedBytes) + 64'(klen);
    unsorted = has_prev && (ord == ORD_LESS || (ord == ORD_EQ &&
               (klen < prev_klen || (klen == prev_klen && cur_val < prev_val))));
    if (unsorted) begin
      halt_with(ERR_UNSORTED);
    end else begin
      recs_seen++;
      prev_klen = klen;
      prev_val  = cur_val;
      has_prev  = 1'b1;
      post(EV_RECORD, ERR_NONE, cur_val, klen[12:0], 1'b0);
      ph  = PH_FIXED;
      pos = 0;
      close_count(fin);
    end
  endtask

  task automatic take_byte(logic [7:0] b, bit fin);
    logic [31:0] hi;
    logic [31:0] lim;
    logic [63:0] rem;
    case (ph)
      PH_HDR, PH_HDR_BAD: begin
        hdr_crc = crc32_fold(hdr_crc, (pos >= HdrCrcAt && pos < HdrCrcAt + 4) ? 8'd0 : b);
        shift_reg = {b, shift_reg[63:8]};
        hi = shift_reg[63:32];
        case (pos)
          7:  if (shift_reg != RunMagic) ph = PH_HDR_BAD;
          11: if (hi != RunFormat) ph = PH_HDR_BAD;
          15: if (hi != HdrBytes) ph = PH_HDR_BAD;
          23: want_recs = shift_reg;
          31: want_bytes = shift_reg;
          35: want_pcrc = hi;
          39: hdr_crc_field = hi;
          default: ;
        endcase
        if (pos < HdrBytes - 1) begin
          pos++;
          if (fin) halt_with(ERR_TRUNCATED);
        end else if (ph == PH_HDR_BAD) begin
          halt_with(ERR_HDR_ID);
        end else if (want_bytes > 64'hFFFF_FFFF_FFFF_FFCF ||
                     shift_reg != 64'(HdrBytes) + want_bytes ||
                     (hdr_crc ^ CrcOnes) != hdr_crc_field) begin
          halt_with(ERR_HDR_CHECK);
        end else begin
          post(EV_HEADER, ERR_NONE, '0, '0, 1'b0);
          ph  = PH_FIXED;
          pos = 0;
          close_count(fin);
        end
      end
      PH_FIXED: begin
        pay_crc   = crc32_fold(pay_crc, b);
        shift_reg = {b, shift_reg[63:8]};
        if (pos == 3) klen = shift_reg[63:32];
        if (pos < FixedBytes - 1) begin
          pos++;
          if (fin) halt_with(ERR_TRUNCATED);
        end else begin
          cur_val = shift_reg;
          lim = 32'(size_limit);
          if (lim < FixedBytes) lim = FixedBytes;
          if (lim > FixedBytes + MaxKeyBytes) lim = FixedBytes + MaxKeyBytes;
          rem = want_bytes - bytes_seen;
          if (want_bytes < bytes_seen || rem < 64'(FixedBytes) ||
              klen > lim - FixedBytes || 64'(klen) > rem - 64'(FixedBytes)) begin
            halt_with(ERR_REC_LEN);
          end else begin
            ord = ORD_EQ;
            pos = 0;
            if (klen == 0) begin
              close_record(fin);
            end else begin
              ph = PH_KEY;
              if (fin) halt_with(ERR_TRUNCATED);
            end
          end
        end
      end
      PH_KEY: begin
        pay_crc = crc32_fold(pay_crc, b);
        if (pos < MaxKeyBytes) begin
          if (ord == ORD_EQ) begin
            if (pos < prev_klen) begin
              if (b < prev_key[pos]) ord = ORD_LESS;
              else if (b > prev_key[pos]) ord = ORD_GREATER;
            end else begin
              ord = ORD_GREATER;
            end
          end
          prev_key[pos] = b;
        end
        pos++;
        if (pos >= klen) close_record(fin);
        else if (fin) halt_with(ERR_TRUNCATED);
      end
      PH_END: halt_with(ERR_TRAILING);
      default: ;
    endcase
  endtask

  task automatic match_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      due_results.delete();
      size_limit    = LimitReset;
      ph            = PH_HDR;
      pos           = 0;
      shift_reg     = 0;
      want_recs     = 0;
      want_bytes    = 0;
      want_pcrc     = 0;
      hdr_crc_field = 0;
      hdr_crc       = CrcOnes;
      pay_crc       = CrcOnes;
      bytes_seen    = 0;
      recs_seen     = 0;
      klen          = 0;
      cur_val       = 0;
      prev_klen     = 0;
      prev_val      = 0;
      has_prev      = 0;
      ord           = ORD_EQ;
      fail_count_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_limit = cfg_data_i;
      if (s_valid_i && s_ready_i) take_byte(s_data_i, s_last_i);
      if (m_valid_i && m_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: kind %0d code %0d", m_user_i, m_data_i[2:0]);
          fail_count_o++;
        end else begin
          e = due_results.pop_front();
          match_field("event_kind", 64'(e.kind), 64'(m_user_i));
          match_field("error_code", 64'(e.err), 64'(m_data_i[2:0]));
          match_field("record_value", e.value, m_data_i[66:3]);
          match_field("key_length", 64'(e.klen), 64'(m_data_i[79:67]));
          match_field("record_number", e.recnum, m_data_i[143:80]);
          match_field("last_of_run", 64'(e.last), 64'(m_last_i));
        end
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ===== test/tb_sorted_run_stream_checker.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_run_stream_checker
// Streams one generated sorted run file through the checker and judges it.
// ----------------------------------------------------------------------------
// The run opens with empty-key records at the value extremes, then keys that
// grow, repeat and bump upward, one of them 256 bytes long. The ending is
// picked at random: clean finish, trailing bytes, early final byte, an
// out-of-order record, a bad payload CRC, an oversize record, or a broken
// header. The size limit is rewritten while idle between record groups.
module tb_sorted_run_stream_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import srsc_pkg::*;

  localparam int BigKeyBytes = 256;

  typedef enum int {
    END_CLEAN, END_TRAILING, END_TRUNCATED, END_UNSORTED,
    END_PAYLOAD, END_LENGTH, END_HDR_ID, END_HDR_CHECK
  } ending_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [12:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata = '0;   // stream_byte
  logic          s_axis_tlast = 1'b0; // final_byte
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [143:0]  m_axis_tdata;        // error_code, record_value, key_length, record_number
  logic [1:0]    m_axis_tuser;        // event_kind
  logic          m_axis_tlast;        // last_of_run

  int            pending;
  int            fail_count;
  bit            calm;
  int            stall_left;

  ending_e       ending;
  byte unsigned  payload[$];
  byte unsigned  key_now[$];
  int unsigned   rec_off[$];
  int unsigned   rec_klen[$];
  byte unsigned  head[48];
  int            n_empty;
  int            big_idx;
  int            n_recs;

  sorted_run_stream_checker dut (.*);

  sorted_run_scoreboard watch (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_last_i(s_axis_tlast),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser), .m_last_i(m_axis_tlast),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always #5 clk_i = ~clk_i;

  // result-side stalls in bursts, none once the run calms down
  always @(negedge clk_i) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic logic [31:0] crc_fold(logic [31:0] crc, byte unsigned b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

  task automatic add_record(logic [63:0] value);
    rec_off.insert(rec_off.size(), payload.size());
    rec_klen.insert(rec_klen.size(), key_now.size());
    for (int i = 0; i < 4; i++) payload.insert(payload.size(), 8'(key_now.size() >> (8 * i)));
    for (int i = 0; i < 8; i++) payload.insert(payload.size(), value[8 * i +: 8]);
    foreach (key_now[i]) payload.insert(payload.size(), key_now[i]);
  endtask

  function automatic void grow_key(int n);
    repeat (n) key_now.insert(key_now.size(), 8'($urandom));
  endfunction

  // next key in nondecreasing order; returns 1 when the key stays the same
  function automatic bit step_key();
    int p;
    int m;
    m = $urandom_range(0, 9);
    if (key_now.size() == 0) begin
      grow_key($urandom_range(1, 5));
      return 0;
    end
    if (key_now.size() <= 20 && m < 2) return 1;
    if (key_now.size() <= 20 && m < 4) begin
      grow_key($urandom_range(1, 4));
      return 0;
    end
    p = $urandom_range(0, (key_now.size() < 4 ? key_now.size() : 4) - 1);
    while (p < key_now.size() && key_now[p] == 8'hFF) p++;
    if (p == key_now.size()) begin
      grow_key($urandom_range(1, 4));
      return 0;
    end
    while (key_now.size() > p + 1) void'(key_now.pop_back());
    key_now[p] = key_now[p] + 8'($urandom_range(1, 255 - key_now[p]));
    grow_key($urandom_range(0, 4));
    return 0;
  endfunction

  function automatic bit group_start(int i);
    return i == n_empty || i == big_idx || i == big_idx + 1 || (i > 0 && i % 20 == 0) ||
           (ending == END_LENGTH && i == n_recs - 1);
  endfunction

  task automatic push_byte(byte unsigned b, bit fin);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every result is out, then let the block go quiet
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [12:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] v;
    logic [63:0] d;
    logic [31:0] crc;
    logic [63:0] fields[4];
    int          fin_at;
    int          seg_max;
    int          j;
    int          bad_kl;
    int          n_body;
    int unsigned r;

    r = $urandom_range(0, 15);
    ending = r < 5 ? END_CLEAN : r < 7 ? END_TRAILING : r < 9 ? END_TRUNCATED :
             r < 11 ? END_UNSORTED : r < 13 ? END_PAYLOAD : r == 13 ? END_LENGTH :
             r == 14 ? END_HDR_ID : END_HDR_CHECK;

    // empty keys first: value 0, an equal repeat, rising values, then all ones
    n_empty = $urandom_range(3, 8);
    v = '0;
    for (int i = 0; i < n_empty; i++) begin
      if (i == n_empty - 1) v = '1;
      else if (i > 1) v = v + ({$urandom, $urandom} >> 4);
      add_record(v);
    end
    big_idx = n_empty + $urandom_range(5, 25);
    n_body  = $urandom_range(30, 40);
    for (int i = n_empty; i < n_empty + n_body; i++) begin
      if (i == big_idx) begin
        void'(step_key());
        grow_key(BigKeyBytes - key_now.size());
        v = {$urandom, $urandom};
      end else if (step_key()) begin
        d = $urandom_range(0, 1);
        if (v + d >= v) v = v + d;
      end else begin
        v = {$urandom, $urandom};
      end
      add_record(v);
    end
    if (ending == END_UNSORTED) begin
      key_now.delete();
      add_record({$urandom, $urandom});
    end else if (ending == END_LENGTH) begin
      bad_kl = $urandom_range(1, 6);
      key_now.delete();
      grow_key(bad_kl);
      add_record({$urandom, $urandom});
    end
    n_recs = rec_off.size();

    crc = CrcOnes;
    foreach (payload[i]) crc = crc_fold(crc, payload[i]);
    crc = crc ^ CrcOnes;
    if (ending == END_PAYLOAD) crc = crc ^ (32'd1 << $urandom_range(0, 31));

    fields = '{RunMagic, {HdrBytes, RunFormat}, 64'(n_recs), 64'(payload.size())};
    for (int i = 0; i < 32; i++) head[i] = fields[i / 8][8 * (i % 8) +: 8];
    for (int i = 0; i < 4; i++) head[32 + i] = crc[8 * i +: 8];
    for (int i = 0; i < 4; i++) head[36 + i] = 8'd0;
    d = 64'(HdrBytes) + 64'(payload.size());
    for (int i = 0; i < 8; i++) head[40 + i] = d[8 * i +: 8];
    crc = CrcOnes;
    foreach (head[i]) crc = crc_fold(crc, head[i]);
    crc = crc ^ CrcOnes;
    for (int i = 0; i < 4; i++) head[36 + i] = crc[8 * i +: 8];
    if (ending == END_HDR_ID) head[$urandom_range(0, 15)] ^= 8'($urandom_range(1, 255));
    if (ending == END_HDR_CHECK) head[$urandom_range(16, 47)] ^= 8'($urandom_range(1, 255));

    fin_at = payload.size() - 1;
    if (ending == END_TRUNCATED) begin
      fin_at = rec_off[n_recs - 1] + $urandom_range(0, 10 + rec_klen[n_recs - 1]);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_limit($urandom_range(0, 1) ? 13'd12 : 13'd0);
    for (int i = 0; i < 48; i++) push_byte(head[i], 1'b0);

    for (int i = 0; i < n_recs; i++) begin
      if (group_start(i)) begin
        drain();
        if (ending == END_LENGTH && i == n_recs - 1) begin
          write_limit(13'(12 + $urandom_range(0, bad_kl - 1)));
        end else begin
          seg_max = 0;
          j = i;
          do begin
            if (rec_klen[j] > seg_max) seg_max = rec_klen[j];
            j++;
          end while (j < n_recs && !group_start(j));
          case ($urandom_range(0, 3))
            0: write_limit(13'h1FFF);
            1: write_limit(13'(12 + seg_max));
            2: write_limit(13'($urandom_range(12 + seg_max, 8191)));
            default: write_limit(seg_max == 0 ? 13'd0 : LimitReset);
          endcase
        end
      end
      for (int k = rec_off[i]; k < rec_off[i] + 12 + rec_klen[i] && k <= fin_at; k++) begin
        if (k > payload.size() * 85 / 100) calm = 1'b1;
        push_byte(payload[k], ending != END_TRAILING && k == fin_at);
      end
    end
    if (ending == END_TRAILING) begin
      r = $urandom_range(1, 3);
      for (int i = 1; i <= r; i++) push_byte(8'($urandom), i == r);
    end
    // the block is halted now and drops these
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'($urandom));
    calm = 1'b1;

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/srsc_pkg.sv
hw/rtl/srsc_out_fifo.sv
hw/rtl/sorted_run_stream_checker.sv
test/sorted_run_scoreboard.sv
test/tb_sorted_run_stream_checker.sv
